FILE: design/srs_pkg.sv
// shared types, widths, register codes and constants for the sine row shift block
package srs_pkg;

    // field widths
    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int TIME_W     = 31;
    localparam int MS_W       = 10;
    localparam int LIN_W      = 12;
    localparam int CYC_W      = 16;
    localparam int HGT_W      = 13;
    localparam int CT_W       = 12;
    localparam int CW_W       = 13;

    // derived datapath widths
    localparam int A_W        = CT_W + 1;           // clip_top + row
    localparam int H2_W       = HGT_W - 1;          // half the layer height
    localparam int TP_W       = TIME_W + H2_W;      // time times half height
    localparam int DEN_W      = CYC_W + LIN_W;      // cycle times lines
    localparam int SINE_W     = 16;
    localparam int PROD_W     = SINE_W + MS_W + 1;
    localparam int Q15_FRAC   = 15;
    localparam int OFS_W      = PROD_W - Q15_FRAC;
    localparam int DIMW       = 14;                 // holds any clip limit up to 8192
    localparam int DC_W       = DIMW + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHIFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_LINES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_CYCLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH   = 3'd5;

    // register values after reset
    localparam logic [MS_W-1:0]  MAX_SHIFT_RST    = 10'd0;
    localparam logic [LIN_W-1:0] WAVE_LINES_RST   = 12'd64;
    localparam logic [CYC_W-1:0] WAVE_CYCLE_RST   = 16'd1000;
    localparam logic [HGT_W-1:0] LAYER_HEIGHT_RST = 13'd480;
    localparam logic [CT_W-1:0]  CLIP_TOP_RST     = 12'd0;
    localparam logic [CW_W-1:0]  CLIP_WIDTH_RST   = 13'd640;

    // parameter defaults
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int PIXEL_BITS_DEF   = 32;
    localparam int MAX_DIM_DEF      = 4096;

    // queue depths
    localparam int MIDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    // sine table build, Q28 fixed point
    localparam longint Q28_ONE      = 64'sd268435456;
    localparam longint TWO_PI_Q28   = 64'sd1686629713;
    localparam longint ROUND_HALF   = 64'sd4096;
    localparam longint ROUND_DIV    = 64'sd8192;
    localparam longint Q15_MAX      = 64'sd32767;
    localparam longint Q15_MIN      = -64'sd32768;
    localparam int     TAYLOR_TERMS = 12;
    localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156,
        64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
    };
    localparam int TRUNC_BIAS = 32767;

    // configuration registers
    typedef struct packed {
        logic [MS_W-1:0]  max_shift;
        logic [LIN_W-1:0] wave_lines;
        logic [CYC_W-1:0] wave_cycle;
        logic [HGT_W-1:0] layer_height;
        logic [CT_W-1:0]  clip_top;
        logic [CW_W-1:0]  clip_width;
    } t_cfg;

    // word held in the queue between front and back, pixel travels beside it
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [A_W-1:0]   a;
        logic [TP_W-1:0]  tprod;
    } t_fq_word;

    // clip width clamped to the largest frame dimension
    function automatic logic [DIMW-1:0] clip_limit(input logic [CW_W-1:0] cw,
                                                   input logic [DIMW-1:0] max_dim);
        logic [DIMW-1:0] w;
        begin
            w = DIMW'(cw);
            return (w > max_dim) ? max_dim : w;
        end
    endfunction

endpackage

FILE: design/srs_fifo.sv
// small register queue with count, used between the stages and on the result side
module srs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    // status and head word
    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rdata   = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: design/srs_front.sv
// front end: takes a word, drops pixels outside the clip, forms the phase terms
module srs_front #(
    parameter int PIXEL_BITS = srs_pkg::PIXEL_BITS_DEF,
    parameter int MAX_DIM    = srs_pkg::MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  srs_pkg::t_cfg            i_cfg,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [PIXEL_BITS-1:0]    i_src_pixel,
    input  logic [srs_pkg::COL_W-1:0]  i_src_column,
    input  logic [srs_pkg::ROW_W-1:0]  i_clip_row,
    input  logic [srs_pkg::TIME_W-1:0] i_frame_time,
    output logic                     o_q_push,
    output logic [PIXEL_BITS-1:0]    o_q_pixel,
    output srs_pkg::t_fq_word        o_q_word,
    input  logic                     i_q_full
);
    import srs_pkg::*;

    logic                  r_vld;
    logic [PIXEL_BITS-1:0] r_px;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [TIME_W-1:0]     r_time;
    logic [DIMW-1:0]       w_limit;
    logic                  w_keep;
    logic [H2_W-1:0]       w_h2;

    // input stage holds while the queue is full
    assign o_full = r_vld && i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_full) begin
            r_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_px   <= i_src_pixel;
            r_col  <= i_src_column;
            r_row  <= i_clip_row;
            r_time <= i_frame_time;
        end
    end

    // a source column beyond the clip never yields a word
    assign w_limit = clip_limit(i_cfg.clip_width, DIMW'(MAX_DIM));
    assign w_keep  = (DIMW'(r_col) < w_limit);
    assign w_h2    = i_cfg.layer_height[HGT_W-1:1];

    // row term and time term for the phase
    assign o_q_push       = r_vld && w_keep && !i_q_full;
    assign o_q_pixel      = r_px;
    assign o_q_word.col   = r_col;
    assign o_q_word.row   = r_row;
    assign o_q_word.a     = A_W'(i_cfg.clip_top) + A_W'(r_row);
    assign o_q_word.tprod = TP_W'(r_time) * TP_W'(w_h2);

endmodule

FILE: design/srs_back.sv
// back end: phase remainder and divide pipeline, sine lookup, offset and clip test
module srs_back #(
    parameter int SINE_ENTRIES = srs_pkg::SINE_ENTRIES_DEF,
    parameter int PIXEL_BITS   = srs_pkg::PIXEL_BITS_DEF,
    parameter int MAX_DIM      = srs_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  srs_pkg::t_cfg             i_cfg,
    input  logic                      i_q_empty,
    input  logic [PIXEL_BITS-1:0]     i_q_pixel,
    input  srs_pkg::t_fq_word         i_q_word,
    output logic                      o_q_pop,
    input  logic                      i_out_full,
    output logic                      o_out_push,
    output logic [PIXEL_BITS-1:0]     o_out_pixel,
    output logic [srs_pkg::COL_W-1:0] o_out_col,
    output logic [srs_pkg::ROW_W-1:0] o_out_row
);
    import srs_pkg::*;

    localparam int QW   = $clog2(SINE_ENTRIES);
    localparam int XW   = DEN_W + QW + 1;
    localparam int NREM = TP_W;
    localparam int LAT  = NREM + QW + 5;

    typedef logic signed [SINE_W-1:0] t_sine_rom [SINE_ENTRIES];

    typedef struct packed {
        logic [A_W-1:0]   a;
        logic [TP_W-1:0]  tprod;
        logic [LIN_W-1:0] rem_a;
        logic [DEN_W-1:0] rem_b;
    } t_rem;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QW-1:0]    low;
        logic [QW-1:0]    quot;
    } t_div;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_side;

    // one Q1.15 sine entry by odd Taylor series in Q28
    function automatic logic signed [SINE_W-1:0] sine_q15(input int k);
        longint kk;
        longint x;
        longint term;
        longint sum;
        longint mag;
        longint r;
        begin
            kk = (k > SINE_ENTRIES / 2) ? longint'(k) - longint'(SINE_ENTRIES)
                                        : longint'(k);
            x    = (kk * TWO_PI_Q28) / SINE_ENTRIES;
            term = x;
            sum  = x;
            for (int n = 0; n < TAYLOR_TERMS; n++) begin
                term = (term * x) / Q28_ONE;
                term = (term * x) / Q28_ONE;
                term = -term / TAYLOR_DIV[n];
                sum  = sum + term;
            end
            mag = (sum < 0) ? -sum : sum;
            mag = (mag + ROUND_HALF) / ROUND_DIV;
            r   = (sum < 0) ? -mag : mag;
            if (r > Q15_MAX) begin
                r = Q15_MAX;
            end
            if (r < Q15_MIN) begin
                r = Q15_MIN;
            end
            return SINE_W'(r);
        end
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        begin
            for (int k = 0; k < SINE_ENTRIES; k++) begin
                rom[k] = sine_q15(k);
            end
            return rom;
        end
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic                     w_adv;
    logic [LAT:0]             r_vld;
    t_side                    r_sb [LAT+1];
    logic [PIXEL_BITS-1:0]    r_px [LAT+1];
    logic [CYC_W-1:0]         r_cyc;
    logic [LIN_W-1:0]         r_lin;
    logic [DEN_W-1:0]         r_den;
    t_rem                     r_rem [NREM+1];
    logic [DEN_W-1:0]         r_terma;
    logic [DEN_W-1:0]         r_remb;
    logic [DEN_W-1:0]         r_phr;
    t_div                     r_div [QW+1];
    logic signed [SINE_W-1:0] r_sine;
    logic signed [PROD_W-1:0] r_prod;
    logic [DEN_W:0]           w_diff;
    logic [XW-1:0]            w_xprod;
    logic signed [PROD_W:0]   w_biased;
    logic signed [OFS_W-1:0]  w_ofs;
    logic signed [DC_W-1:0]   w_dc;
    logic [DIMW-1:0]          w_limit;
    logic                     w_emit;

    // the whole pipe moves while the result queue has room
    assign w_adv   = !i_out_full;
    assign o_q_pop = w_adv && !i_q_empty;

    // cycle and lines with zero taken as one, and their product
    always_ff @(posedge i_clk) begin
        r_cyc <= (i_cfg.wave_cycle == '0) ? CYC_W'(1) : i_cfg.wave_cycle;
        r_lin <= (i_cfg.wave_lines == '0) ? LIN_W'(1) : i_cfg.wave_lines;
        r_den <= DEN_W'(r_cyc * r_lin);
    end

    // valid bits along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-1:0], !i_q_empty};
        end
    end

    // pixel, column and row ride beside the arithmetic
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb[0].col <= i_q_word.col;
            r_sb[0].row <= i_q_word.row;
            r_px[0]     <= i_q_pixel;
            for (int i = 1; i <= LAT; i++) begin
                r_sb[i] <= r_sb[i-1];
                r_px[i] <= r_px[i-1];
            end
        end
    end

    // load the remainder pipe from the queue head
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem[0].a     <= i_q_word.a;
            r_rem[0].tprod <= i_q_word.tprod;
            r_rem[0].rem_a <= '0;
            r_rem[0].rem_b <= '0;
        end
    end

    // one restoring step per stage: row term mod lines, time term mod cycle*lines
    for (genvar i = 0; i < NREM; i++) begin : g_rem
        logic [DEN_W:0]   w_shb;
        logic [DEN_W-1:0] w_nrb;
        logic [LIN_W-1:0] w_nra;

        assign w_shb = {r_rem[i].rem_b, r_rem[i].tprod[TP_W-1-i]};
        assign w_nrb = (w_shb >= {1'b0, r_den}) ? DEN_W'(w_shb - {1'b0, r_den})
                                                : w_shb[DEN_W-1:0];

        if (i < A_W) begin : g_a
            logic [LIN_W:0] w_sha;
            assign w_sha = {r_rem[i].rem_a, r_rem[i].a[A_W-1-i]};
            assign w_nra = (w_sha >= {1'b0, r_lin}) ? LIN_W'(w_sha - {1'b0, r_lin})
                                                    : w_sha[LIN_W-1:0];
        end else begin : g_hold
            assign w_nra = r_rem[i].rem_a;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[i+1].a     <= r_rem[i].a;
                r_rem[i+1].tprod <= r_rem[i].tprod;
                r_rem[i+1].rem_a <= w_nra;
                r_rem[i+1].rem_b <= w_nrb;
            end
        end
    end

    // row term back to modulo cycle*lines, then the phase remainder
    assign w_diff  = {1'b0, r_terma} - {1'b0, r_remb};
    assign w_xprod = XW'(r_phr) * XW'(SINE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_terma     <= DEN_W'(r_cyc * r_rem[NREM].rem_a);
            r_remb      <= r_rem[NREM].rem_b;
            r_phr       <= w_diff[DEN_W] ? DEN_W'(w_diff + {1'b0, r_den})
                                         : w_diff[DEN_W-1:0];
            r_div[0].rem  <= DEN_W'(w_xprod >> QW);
            r_div[0].low  <= w_xprod[QW-1:0];
            r_div[0].quot <= '0;
        end
    end

    // table index, one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DEN_W:0] w_sh;
        logic           w_ge;

        assign w_sh = {r_div[j].rem, r_div[j].low[QW-1-j]};
        assign w_ge = (w_sh >= {1'b0, r_den});

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_div[j+1].rem  <= w_ge ? DEN_W'(w_sh - {1'b0, r_den}) : w_sh[DEN_W-1:0];
                r_div[j+1].low  <= r_div[j].low;
                r_div[j+1].quot <= {r_div[j].quot[QW-2:0], w_ge};
            end
        end
    end

    // sine read and amplitude scaling
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sine <= SINE_ROM[r_div[QW].quot];
            r_prod <= PROD_W'(r_sine * $signed({1'b0, i_cfg.max_shift}));
        end
    end

    // offset truncated toward zero, destination column and clip test
    assign w_biased = {r_prod[PROD_W-1], r_prod}
                    + (r_prod[PROD_W-1] ? (PROD_W+1)'(TRUNC_BIAS) : '0);
    assign w_ofs    = w_biased[PROD_W-1:Q15_FRAC];
    assign w_dc     = $signed(DC_W'(r_sb[LAT].col)) + DC_W'(w_ofs);
    assign w_limit  = clip_limit(i_cfg.clip_width, DIMW'(MAX_DIM));
    assign w_emit   = !w_dc[DC_W-1] && (w_dc[DIMW-1:0] < w_limit);

    assign o_out_push  = w_adv && r_vld[LAT] && w_emit;
    assign o_out_pixel = r_px[LAT];
    assign o_out_col   = w_dc[COL_W-1:0];
    assign o_out_row   = r_sb[LAT].row;

endmodule

FILE: design/sine_raster_row_shift_top.sv
// top level of the sine row shift: registers, front end, queues and back end
//
//  port group     direction  handshake            contents
//  input words    in         push / full          src_pixel, src_column, clip_row, frame_time
//  result words   out        empty / pop          dst_pixel, dst_column, dst_row
//  registers      in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one word per clock sustained in both directions when the result side keeps up
// the path from push to empty falling runs through the bit-per-stage remainder of
// the 43-bit time term and the index divide
// i_rst_n is synchronous and active low; registers return to their reset values
// a full result queue halts the back end, the middle queue then fills and full rises
// words that land outside the clip produce nothing and leave no gap in the output
module sine_raster_row_shift_top #(
    parameter int SINE_ENTRIES = srs_pkg::SINE_ENTRIES_DEF,
    parameter int PIXEL_BITS   = srs_pkg::PIXEL_BITS_DEF,
    parameter int MAX_DIM      = srs_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [PIXEL_BITS-1:0]         i_src_pixel,
    input  logic [srs_pkg::COL_W-1:0]      i_src_column,
    input  logic [srs_pkg::ROW_W-1:0]      i_clip_row,
    input  logic [srs_pkg::TIME_W-1:0]     i_frame_time,
    output logic                          empty,
    input  logic                          pop,
    output logic [PIXEL_BITS-1:0]         o_dst_pixel,
    output logic [srs_pkg::COL_W-1:0]      o_dst_column,
    output logic [srs_pkg::ROW_W-1:0]      o_dst_row
);
    import srs_pkg::*;

    localparam int FQ_W  = $bits(t_fq_word);
    localparam int MQ_W  = PIXEL_BITS + FQ_W;
    localparam int OQ_W  = PIXEL_BITS + COL_W + ROW_W;

    t_cfg                  r_cfg;
    logic                  fq_push;
    logic [PIXEL_BITS-1:0] fq_pixel;
    t_fq_word              fq_word;
    logic                  mq_full;
    logic                  mq_empty;
    logic                  mq_pop;
    logic [MQ_W-1:0]       mq_rdata;
    t_fq_word              mq_word;
    logic                  oq_full;
    logic                  oq_push;
    logic [PIXEL_BITS-1:0] oq_pixel;
    logic [COL_W-1:0]      oq_col;
    logic [ROW_W-1:0]      oq_row;
    logic [OQ_W-1:0]       oq_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_shift    <= MAX_SHIFT_RST;
            r_cfg.wave_lines   <= WAVE_LINES_RST;
            r_cfg.wave_cycle   <= WAVE_CYCLE_RST;
            r_cfg.layer_height <= LAYER_HEIGHT_RST;
            r_cfg.clip_top     <= CLIP_TOP_RST;
            r_cfg.clip_width   <= CLIP_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_SHIFT:    r_cfg.max_shift    <= i_cfg_data[MS_W-1:0];
                CFG_WAVE_LINES:   r_cfg.wave_lines   <= i_cfg_data[LIN_W-1:0];
                CFG_WAVE_CYCLE:   r_cfg.wave_cycle   <= i_cfg_data[CYC_W-1:0];
                CFG_LAYER_HEIGHT: r_cfg.layer_height <= i_cfg_data[HGT_W-1:0];
                CFG_CLIP_TOP:     r_cfg.clip_top     <= i_cfg_data[CT_W-1:0];
                CFG_CLIP_WIDTH:   r_cfg.clip_width   <= i_cfg_data[CW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    srs_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .o_full       (full),
        .i_src_pixel  (i_src_pixel),
        .i_src_column (i_src_column),
        .i_clip_row   (i_clip_row),
        .i_frame_time (i_frame_time),
        .o_q_push     (fq_push),
        .o_q_pixel    (fq_pixel),
        .o_q_word     (fq_word),
        .i_q_full     (mq_full)
    );

    // queue between front and back
    srs_fifo #(
        .WIDTH (MQ_W),
        .DEPTH (MIDQ_DEPTH)
    ) u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_wdata ({fq_pixel, fq_word}),
        .i_pop   (mq_pop),
        .o_rdata (mq_rdata),
        .o_full  (mq_full),
        .o_empty (mq_empty)
    );

    assign mq_word = t_fq_word'(mq_rdata[FQ_W-1:0]);

    // back end
    srs_back #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .PIXEL_BITS   (PIXEL_BITS),
        .MAX_DIM      (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (mq_empty),
        .i_q_pixel   (mq_rdata[FQ_W +: PIXEL_BITS]),
        .i_q_word    (mq_word),
        .o_q_pop     (mq_pop),
        .i_out_full  (oq_full),
        .o_out_push  (oq_push),
        .o_out_pixel (oq_pixel),
        .o_out_col   (oq_col),
        .o_out_row   (oq_row)
    );

    // result queue
    srs_fifo #(
        .WIDTH (OQ_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_wdata ({oq_pixel, oq_col, oq_row}),
        .i_pop   (pop),
        .o_rdata (oq_rdata),
        .o_full  (oq_full),
        .o_empty (empty)
    );

    assign o_dst_pixel  = oq_rdata[COL_W + ROW_W +: PIXEL_BITS];
    assign o_dst_column = oq_rdata[ROW_W +: COL_W];
    assign o_dst_row    = oq_rdata[ROW_W-1:0];

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// testbench for the sine row shift block: queued driver, checking monitor and row offset model
module tb;
    import srs_pkg::*;

    localparam int SINE_N       = SINE_ENTRIES_DEF;
    localparam int PIX_W        = PIXEL_BITS_DEF;
    localparam int DIM_LIMIT    = MAX_DIM_DEF;
    localparam int DRAIN_CYCLES = 80;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_WORDS  = 40;

    // one source word and one destination word
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [TIME_W-1:0] ftime;
    } t_src_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_dst_word;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  push         = 1'b0;
    logic                  full;
    logic [PIX_W-1:0]      i_src_pixel  = '0;
    logic [COL_W-1:0]      i_src_column = '0;
    logic [ROW_W-1:0]      i_clip_row   = '0;
    logic [TIME_W-1:0]     i_frame_time = '0;
    logic                  empty;
    logic                  pop          = 1'b0;
    logic [PIX_W-1:0]      o_dst_pixel;
    logic [COL_W-1:0]      o_dst_column;
    logic [ROW_W-1:0]      o_dst_row;

    sine_raster_row_shift_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_src_pixel  (i_src_pixel),
        .i_src_column (i_src_column),
        .i_clip_row   (i_clip_row),
        .i_frame_time (i_frame_time),
        .empty        (empty),
        .pop          (pop),
        .o_dst_pixel  (o_dst_pixel),
        .o_dst_column (o_dst_column),
        .o_dst_row    (o_dst_row)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // local copy of the registers
    logic [MS_W-1:0]  amp_reg    = MAX_SHIFT_RST;
    logic [LIN_W-1:0] lines_reg  = WAVE_LINES_RST;
    logic [CYC_W-1:0] cycle_reg  = WAVE_CYCLE_RST;
    logic [HGT_W-1:0] height_reg = LAYER_HEIGHT_RST;
    logic [CT_W-1:0]  top_reg    = CLIP_TOP_RST;
    logic [CW_W-1:0]  width_reg  = CLIP_WIDTH_RST;

    shortint   wave_rom [SINE_N];
    t_src_word src_words[$];
    t_dst_word shifted_words[$];
    t_src_word on_port;
    t_src_word next_word;
    t_dst_word due_word;
    t_dst_word want;

    int queued_n   = 0;
    int taken_n    = 0;
    int checked_n  = 0;
    int dropped_n  = 0;
    int mismatches = 0;
    int settings_n = 0;
    int gap_left   = 0;
    int stall_left = 0;
    bit gap_on     = 1'b0;
    bit stall_on   = 1'b0;

    // q1.15 sine entry from an odd taylor series in q28, truncating steps
    function automatic shortint taylor_sine(input int k);
        longint kk, x, term, acc, mag;
        int     n;
        kk = k;
        if (k > SINE_N / 2)
            kk = kk - SINE_N;
        x = (kk * TWO_PI_Q28) / SINE_N;
        term = x;
        acc = x;
        for (n = 1; n <= 12; n++) begin
            term = (term * x) / Q28_ONE;
            term = (term * x) / Q28_ONE;
            term = -term / longint'((2 * n) * (2 * n + 1));
            acc = acc + term;
        end
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + 4096) / 8192;
        acc = (acc < 0) ? -mag : mag;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        return shortint'(acc);
    endfunction

    // row offset from the sine wave, word kept only if it lands inside the clip
    function automatic bit shift_row(input t_src_word w, output t_dst_word r);
        longint cyc, lin, width, h2, rw, cl, tm, num, den, q, p, d, dc;
        cyc = cycle_reg;
        if (cyc == 0)
            cyc = 1;
        lin = lines_reg;
        if (lin == 0)
            lin = 1;
        width = width_reg;
        if (width > DIM_LIMIT)
            width = DIM_LIMIT;
        h2 = height_reg;
        h2 = h2 / 2;
        rw = w.row;
        cl = w.col;
        tm = w.ftime;
        num = top_reg;
        num = ((num + rw) * cyc - tm * h2) * SINE_N;
        den = cyc * lin;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        p = q % SINE_N;
        if (p < 0)
            p = p + SINE_N;
        d = wave_rom[p];
        q = amp_reg;
        d = (d * q) / 32768;
        dc = cl + d;
        r.pixel = w.pixel;
        r.col = COL_W'(dc);
        r.row = w.row;
        return (cl < width) && (dc >= 0) && (dc < width);
    endfunction

    // idle length, mostly short with the odd long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register value: extremes, junk above the field, or in range
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input int w);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CFG_DATA_W'((1 << w) - 1);
        if (r == 2)
            return CFG_DATA_W'(1);
        if (r == 3)
            return CFG_DATA_W'($urandom_range(0, 65535));
        return CFG_DATA_W'($urandom_range(0, (1 << w) - 1));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_MAX_SHIFT:    amp_reg    = val[MS_W-1:0];
            CFG_WAVE_LINES:   lines_reg  = val[LIN_W-1:0];
            CFG_WAVE_CYCLE:   cycle_reg  = val[CYC_W-1:0];
            CFG_LAYER_HEIGHT: height_reg = val[HGT_W-1:0];
            CFG_CLIP_TOP:     top_reg    = val[CT_W-1:0];
            CFG_CLIP_WIDTH:   width_reg  = val[CW_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_regs(input logic [CFG_DATA_W-1:0] amp, lin, cyc, hgt, top, wid);
        write_reg(CFG_MAX_SHIFT, amp);
        write_reg(CFG_WAVE_LINES, lin);
        write_reg(CFG_WAVE_CYCLE, cyc);
        write_reg(CFG_LAYER_HEIGHT, hgt);
        write_reg(CFG_CLIP_TOP, top);
        write_reg(CFG_CLIP_WIDTH, wid);
        settings_n++;
    endtask

    task automatic add_word(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
                            input logic [ROW_W-1:0] row, input logic [TIME_W-1:0] tm);
        t_src_word w;
        w.pixel = pix;
        w.col = col;
        w.row = row;
        w.ftime = tm;
        src_words.push_back(w);
        queued_n++;
    endtask

    // wait for every word taken and every result back, then let the pipe empty
    task automatic drain();
        while (taken_n != queued_n || shifted_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                taken_n++;
                if (shift_row(on_port, due_word))
                    shifted_words.push_back(due_word);
                else
                    dropped_n++;
            end
            // a refused word stays on the ports
            if (!(push && full)) begin
                if (gap_left != 0) begin
                    push <= 1'b0;
                    gap_left--;
                end else if (src_words.size() != 0) begin
                    next_word = src_words.pop_front();
                    on_port      <= next_word;
                    i_src_pixel  <= next_word.pixel;
                    i_src_column <= next_word.col;
                    i_clip_row   <= next_word.row;
                    i_frame_time <= next_word.ftime;
                    push         <= 1'b1;
                    gap_left = gap_on ? idle_len() : 0;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (shifted_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word pixel=%h col=%0d row=%0d",
                             $time, o_dst_pixel, o_dst_column, o_dst_row);
                end else begin
                    want = shifted_words.pop_front();
                    checked_n++;
                    if (o_dst_pixel !== want.pixel) begin
                        mismatches++;
                        $display("%0t: dst_pixel expected %h got %h",
                                 $time, want.pixel, o_dst_pixel);
                    end
                    if (o_dst_column !== want.col) begin
                        mismatches++;
                        $display("%0t: dst_column expected %0d got %0d",
                                 $time, want.col, o_dst_column);
                    end
                    if (o_dst_row !== want.row) begin
                        mismatches++;
                        $display("%0t: dst_row expected %0d got %0d",
                                 $time, want.row, o_dst_row);
                    end
                end
                stall_left = stall_on ? idle_len() : 0;
            end
            if (stall_left != 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int k, ph, n, run, lim;
        logic [COL_W-1:0]  c;
        logic [ROW_W-1:0]  r;
        logic [TIME_W-1:0] t;
        for (k = 0; k < SINE_N; k++)
            wave_rom[k] = taylor_sine(k);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, no offset: clip edge and field extremes
        @(negedge i_clk);
        add_word(32'h0000_0000, 12'd0, 12'd0, 31'd0);
        add_word(32'hFFFF_FFFF, 12'd639, 12'd4095, 31'h7FFF_FFFF);
        add_word(32'hA5A5_5A5A, 12'd640, 12'd5, 31'd100);
        add_word(32'h0000_1234, 12'd4095, 12'd0, 31'd0);
        drain();

        // full amplitude, widest legal clip: wave crest, trough and negative phase
        load_regs(16'd1023, 16'd64, 16'd1000, 16'd480, 16'd0, 16'd4096);
        gap_on = 1'b1;
        stall_on = 1'b1;
        @(negedge i_clk);
        add_word(32'h0000_0001, 12'd0, 12'd16, 31'd0);
        add_word(32'h8000_0000, 12'd0, 12'd48, 31'd0);
        add_word(32'hFFFF_FFFF, 12'd4095, 12'd48, 31'd0);
        add_word(32'h5555_AAAA, 12'd4095, 12'd16, 31'd0);
        add_word(32'h0000_FFFF, 12'd0, 12'd0, 31'h7FFF_FFFF);
        add_word(32'hFFFF_0000, 12'd2048, 12'd4095, 31'd12345);
        add_word(32'h2468_ACE0, 12'd2048, 12'd8, 31'd7);
        add_word(32'h1357_9BDF, 12'd1, 12'd32, 31'd3);
        drain();

        // zero lines and cycle, clip width above the frame limit, largest top and height
        load_regs(16'd512, 16'd0, 16'd0, 16'd8191, 16'd4095, 16'd8191);
        @(negedge i_clk);
        add_word(32'h0F0F_F0F0, 12'd0, 12'd4095, 31'd0);
        add_word(32'h8000_0001, 12'd100, 12'd1, 31'd1);
        add_word(32'h7FFF_FFFE, 12'd4095, 12'd4095, 31'h7FFF_FFFF);
        add_word(32'hDEAD_BEEF, 12'd2000, 12'd0, 31'h4000_0000);
        drain();

        // empty clip: nothing comes out
        load_regs(16'd1023, 16'd64, 16'd1000, 16'd480, 16'd0, 16'd0);
        @(negedge i_clk);
        add_word(32'hCAFE_F00D, 12'd0, 12'd0, 31'd0);
        add_word(32'h0BAD_CAFE, 12'd5, 12'd16, 31'd0);
        drain();

        // one column clip, longest wave, slowest cycle, smallest height
        load_regs(16'd0, 16'd4095, 16'd65535, 16'd1, 16'd0, 16'd1);
        @(negedge i_clk);
        add_word(32'hFFFF_FFFF, 12'd0, 12'd7, 31'd99);
        add_word(32'h0000_0001, 12'd1, 12'd7, 31'd99);
        drain();

        // random settings, raster runs along a row mixed with scattered words
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            load_regs(pick_reg(MS_W), pick_reg(LIN_W), pick_reg(CYC_W),
                      pick_reg(HGT_W), pick_reg(CT_W), pick_reg(CW_W));
            @(negedge i_clk);
            gap_on = (ph % 3) != 0;
            stall_on = (ph % 4) != 1;
            lim = (width_reg > DIM_LIMIT) ? DIM_LIMIT : width_reg;
            n = 0;
            while (n < PHASE_WORDS) begin
                if ($urandom_range(0, 3) == 0)
                    t = TIME_W'($urandom_range(0, 5000));
                else
                    t = TIME_W'($urandom);
                r = ROW_W'($urandom_range(0, 4095));
                if (lim > 0 && $urandom_range(0, 4) != 0)
                    c = COL_W'($urandom_range(0, lim - 1));
                else
                    c = COL_W'($urandom_range(0, 4095));
                if ($urandom_range(0, 1) == 1) begin
                    run = $urandom_range(4, 12);
                    for (k = 0; k < run; k++)
                        add_word(PIX_W'($urandom), c + COL_W'(k), r, t);
                    n = n + run;
                end else begin
                    add_word(PIX_W'($urandom), c, r, t);
                    n++;
                end
            end
            drain();
        end

        $display("%0d words sent under %0d register settings", queued_n, settings_n);
        $display("%0d shifted words checked, %0d fell outside the clip", checked_n, dropped_n);
        if (mismatches == 0)
            $display("** sine_raster_row_shift_top: PASSED **");
        else
            $display("** sine_raster_row_shift_top: FAILED **");
        $finish;
    end

    // overall time limit
    initial begin
        #500000;
        $display("timeout: %0d words taken of %0d, %0d results outstanding",
                 taken_n, queued_n, shifted_words.size());
        $display("** sine_raster_row_shift_top: FAILED **");
        $finish;
    end

endmodule
